// ===== rtl/conditional_block_token_filter_top_macros.svh =====
// ----------------------------------------------------------------------------
// conditional_block_token_filter_top_macros
// Assertion helpers for the token filter; clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef CONDITIONAL_BLOCK_TOKEN_FILTER_TOP_MACROS_SVH
`define CONDITIONAL_BLOCK_TOKEN_FILTER_TOP_MACROS_SVH

// same-cycle implication
`define CBTF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CBTF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/cbtf_pkg.sv =====
// ----------------------------------------------------------------------------
// cbtf_pkg
// Shared types and codes of the conditional block token filter.
// ----------------------------------------------------------------------------
package cbtf_pkg;

  localparam int unsigned NestDepthDef = 16;
  localparam int unsigned LineW        = 24;
  localparam int unsigned OpW          = 3;
  localparam int unsigned ErrW         = 3;

  // token kinds; the two unused codes behave as ordinary tokens
  localparam logic [OpW-1:0] OP_TOKEN  = 3'd0;
  localparam logic [OpW-1:0] OP_IF     = 3'd1;
  localparam logic [OpW-1:0] OP_ELSEIF = 3'd2;
  localparam logic [OpW-1:0] OP_ELSE   = 3'd3;
  localparam logic [OpW-1:0] OP_ENDIF  = 3'd4;
  localparam logic [OpW-1:0] OP_EOI    = 3'd5;

  localparam logic [ErrW-1:0] ERR_NONE          = 3'd0;
  localparam logic [ErrW-1:0] ERR_ELSEIF_NO_IF  = 3'd1;
  localparam logic [ErrW-1:0] ERR_ELSEIF_AFTER  = 3'd2;
  localparam logic [ErrW-1:0] ERR_ELSE_NO_IF    = 3'd3;
  localparam logic [ErrW-1:0] ERR_ELSE_AFTER    = 3'd4;
  localparam logic [ErrW-1:0] ERR_ENDIF_NO_IF   = 3'd5;
  localparam logic [ErrW-1:0] ERR_UNCLOSED      = 3'd6;
  localparam logic [ErrW-1:0] ERR_OVERFLOW      = 3'd7;

  typedef struct packed {
    logic             seen;
    logic             doelse;
    logic             active;
    logic [LineW-1:0] line;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;    // capture the input beat, read top of stack
    logic commit;    // apply the directive, load its result if any
    logic drain;     // report one unclosed level and pop it
    logic emit_end;  // load the end marker
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic has_result;
    logic is_eoi;
    logic depth_zero;
    logic depth_le1;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/cbtf_tok_if.sv =====
// ----------------------------------------------------------------------------
// cbtf_tok_if
// Input token channel: valid/ready with the token payload.
// ----------------------------------------------------------------------------
interface cbtf_tok_if;
  logic                             valid;
  logic                             ready;
  logic [cbtf_pkg::OpW-1:0]         op;
  logic                             cond;
  logic [cbtf_pkg::LineW-1:0]       line;

  modport source (output valid, output op, output cond, output line, input ready);
  modport sink   (input valid, input op, input cond, input line, output ready);
endinterface

// ===== rtl/cbtf_res_if.sv =====
// ----------------------------------------------------------------------------
// cbtf_res_if
// Result channel: valid/ready with pass flag, error report and last marker.
// ----------------------------------------------------------------------------
interface cbtf_res_if;
  logic                             valid;
  logic                             ready;
  logic                             pass;
  logic [cbtf_pkg::ErrW-1:0]        err_code;
  logic [cbtf_pkg::LineW-1:0]       err_line;
  logic                             last;

  modport source (output valid, output pass, output err_code, output err_line,
                  output last, input ready);
  modport sink   (input valid, input pass, input err_code, input err_line,
                  input last, output ready);
endinterface

// ===== rtl/conditional_block_token_filter_top.sv =====
// ----------------------------------------------------------------------------
// conditional_block_token_filter_top
// Conditional-compilation token filter with a nesting stack.
// ----------------------------------------------------------------------------
// One token at a time: a token is taken in the idle state and executed in the
// execute state once the result register is free or it yields no result; no
// new token is taken before that. The nesting stack is a memory with one
// registered read port; each token needs the top level read before it can
// execute. End of input reports the unclosed levels, innermost first, one per
// cycle while the result register is free, then the end marker. Results wait
// in an output register that is refilled in the cycle it is taken. No clearing
// pass after reset: only levels below the depth counter are ever read.
module conditional_block_token_filter_top #(
  parameter int unsigned NEST_DEPTH = cbtf_pkg::NestDepthDef
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  cbtf_tok_if.sink   tok_i,
  cbtf_res_if.source res_o
);

  `include "conditional_block_token_filter_top_macros.svh"

  cbtf_pkg::cmd_t cmd;
  cbtf_pkg::sts_t sts;
  logic           in_ready;

  cbtf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (tok_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cbtf_datapath #(
    .NEST_DEPTH (NEST_DEPTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .op_i           (tok_i.op),
    .cond_i         (tok_i.cond),
    .line_i         (tok_i.line),
    .out_ready_i    (res_o.ready),
    .out_valid_o    (res_o.valid),
    .out_pass_o     (res_o.pass),
    .out_err_code_o (res_o.err_code),
    .out_err_line_o (res_o.err_line),
    .out_last_o     (res_o.last)
  );

  assign tok_i.ready = in_ready;

  `CBTF_ASSERT_NEXT(a_busy_after_accept, tok_i.valid && tok_i.ready, !tok_i.ready, "ready high right after an accepted beat")
  `CBTF_ASSERT_NOW(a_pass_is_clean, res_o.valid && res_o.pass, (res_o.err_code == cbtf_pkg::ERR_NONE) && res_o.last, "forwarded beat carries an error or is not last")
  `CBTF_ASSERT_NOW(a_unclosed_not_last, res_o.valid && (res_o.err_code == cbtf_pkg::ERR_UNCLOSED), !res_o.last && !res_o.pass, "unclosed-level report marked last or pass")
  `CBTF_ASSERT_NOW(a_one_command, 1'b1, $onehot0({cmd.accept, cmd.commit, cmd.drain, cmd.emit_end}), "more than one datapath command in a cycle")

endmodule

// ===== rtl/cbtf_ctrl.sv =====
// ----------------------------------------------------------------------------
// cbtf_ctrl
// Sequencer: accept, execute, drain of unclosed levels, end marker.
// ----------------------------------------------------------------------------
module cbtf_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  cbtf_pkg::sts_t sts_i,
  output cbtf_pkg::cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DRAIN,
    S_END
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts_i.is_eoi) begin
          state_d = sts_i.depth_zero ? S_END : S_DRAIN;
        end else if (!sts_i.has_result || sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_DRAIN: begin
        if (sts_i.out_free) begin
          cmd_o.drain = 1'b1;
          if (sts_i.depth_le1) state_d = S_END;
        end
      end
      S_END: begin
        if (sts_i.out_free) begin
          cmd_o.emit_end = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/cbtf_datapath.sv =====
// ----------------------------------------------------------------------------
// cbtf_datapath
// Nesting stack memory, depth counter, directive decode and result register.
// ----------------------------------------------------------------------------
module cbtf_datapath #(
  parameter int unsigned NEST_DEPTH = cbtf_pkg::NestDepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cbtf_pkg::cmd_t                cmd_i,
  output cbtf_pkg::sts_t                sts_o,
  input  logic [cbtf_pkg::OpW-1:0]      op_i,
  input  logic                          cond_i,
  input  logic [cbtf_pkg::LineW-1:0]    line_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic                          out_pass_o,
  output logic [cbtf_pkg::ErrW-1:0]     out_err_code_o,
  output logic [cbtf_pkg::LineW-1:0]    out_err_line_o,
  output logic                          out_last_o
);

  localparam int unsigned IdxW = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
  localparam int unsigned DepW = $clog2(NEST_DEPTH + 1);

  // captured token
  logic [cbtf_pkg::OpW-1:0]   op_q;
  logic                       cond_q;
  logic [cbtf_pkg::LineW-1:0] line_q;

  logic [DepW-1:0] depth_q, depth_d, depth_m1;
  cbtf_pkg::entry_t mem [NEST_DEPTH];
  cbtf_pkg::entry_t rd_q;  // top of stack, registered read

  logic                 rd_en;
  logic [DepW-1:0]      rd_ptr;
  logic [IdxW-1:0]      rd_addr;
  logic                 wr_en;
  logic [IdxW-1:0]      wr_addr;
  cbtf_pkg::entry_t     wr_data;

  logic                       has_top, full, top_live;
  logic                       res_emit, res_pass;
  logic [cbtf_pkg::ErrW-1:0]  res_code;
  logic                       do_push, do_pop, do_mod;
  cbtf_pkg::entry_t           push_ent, mod_ent;

  logic                       out_valid_q;
  logic                       out_pass_q, out_last_q;
  logic [cbtf_pkg::ErrW-1:0]  out_code_q;
  logic [cbtf_pkg::LineW-1:0] out_line_q;

  assign has_top  = (depth_q != '0);
  assign full     = (depth_q == DepW'(NEST_DEPTH));
  assign top_live = !has_top || rd_q.active;
  assign depth_m1 = depth_q - DepW'(1);

  // directive decode against the current top level
  always_comb begin
    res_emit = 1'b0;
    res_pass = 1'b0;
    res_code = cbtf_pkg::ERR_NONE;
    do_push  = 1'b0;
    do_pop   = 1'b0;
    do_mod   = 1'b0;
    mod_ent  = rd_q;
    push_ent = '{seen: 1'b0, doelse: 1'b0, active: 1'b0, line: line_q};
    case (op_q)
      cbtf_pkg::OP_IF: begin
        if (full) begin
          res_emit = 1'b1;
          res_code = cbtf_pkg::ERR_OVERFLOW;
        end else begin
          do_push         = 1'b1;
          push_ent.active = top_live & cond_q;
          push_ent.doelse = top_live & ~cond_q;
        end
      end
      cbtf_pkg::OP_ELSEIF: begin
        if (!has_top) begin
          // acts as an if opened at the outermost level
          res_emit        = 1'b1;
          res_code        = cbtf_pkg::ERR_ELSEIF_NO_IF;
          do_push         = 1'b1;
          push_ent.active = cond_q;
          push_ent.doelse = ~cond_q;
        end else if (rd_q.seen) begin
          res_emit       = 1'b1;
          res_code       = cbtf_pkg::ERR_ELSEIF_AFTER;
          do_mod         = 1'b1;
          mod_ent.active = 1'b0;
        end else if (cond_q) begin
          do_mod         = 1'b1;
          mod_ent.active = rd_q.doelse;
          mod_ent.doelse = 1'b0;
        end else begin
          do_mod         = 1'b1;
          mod_ent.active = 1'b0;
        end
      end
      cbtf_pkg::OP_ELSE: begin
        if (!has_top) begin
          res_emit = 1'b1;
          res_code = cbtf_pkg::ERR_ELSE_NO_IF;
        end else if (rd_q.seen) begin
          res_emit       = 1'b1;
          res_code       = cbtf_pkg::ERR_ELSE_AFTER;
          do_mod         = 1'b1;
          mod_ent.active = 1'b0;
        end else begin
          do_mod         = 1'b1;
          mod_ent.seen   = 1'b1;
          mod_ent.active = rd_q.doelse;
        end
      end
      cbtf_pkg::OP_ENDIF: begin
        if (!has_top) begin
          res_emit = 1'b1;
          res_code = cbtf_pkg::ERR_ENDIF_NO_IF;
        end else begin
          do_pop = 1'b1;
        end
      end
      cbtf_pkg::OP_EOI: begin
        // handled by the drain sequence
      end
      default: begin
        if (top_live) begin
          res_emit = 1'b1;
          res_pass = 1'b1;
        end
      end
    endcase
  end

  always_comb begin
    depth_d = depth_q;
    if (cmd_i.commit && do_push) depth_d = depth_q + DepW'(1);
    if ((cmd_i.commit && do_pop) || cmd_i.drain) depth_d = depth_m1;
  end

  // read the level that will be on top after this cycle
  assign rd_ptr  = depth_d - DepW'(1);
  assign rd_addr = rd_ptr[IdxW-1:0];
  assign rd_en   = (cmd_i.accept || cmd_i.drain) && (depth_d != '0);

  assign wr_en   = cmd_i.commit && (do_push || do_mod);
  assign wr_addr = do_push ? depth_q[IdxW-1:0] : depth_m1[IdxW-1:0];
  assign wr_data = do_push ? push_ent : mod_ent;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q   <= op_i;
      cond_q <= cond_i;
      line_q <= line_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= '0;
    end else begin
      depth_q <= depth_d;
    end
  end

  // result register; a new beat may load while the old one leaves
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((cmd_i.commit && res_emit) || cmd_i.drain || cmd_i.emit_end) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && res_emit) begin
      out_pass_q <= res_pass;
      out_code_q <= res_code;
      out_line_q <= res_pass ? '0 : line_q;
      out_last_q <= 1'b1;
    end else if (cmd_i.drain) begin
      out_pass_q <= 1'b0;
      out_code_q <= cbtf_pkg::ERR_UNCLOSED;
      out_line_q <= rd_q.line;
      out_last_q <= 1'b0;
    end else if (cmd_i.emit_end) begin
      out_pass_q <= 1'b1;
      out_code_q <= cbtf_pkg::ERR_NONE;
      out_line_q <= '0;
      out_last_q <= 1'b1;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_pass_o     = out_pass_q;
  assign out_err_code_o = out_code_q;
  assign out_err_line_o = out_line_q;
  assign out_last_o     = out_last_q;

  assign sts_o.has_result = res_emit;
  assign sts_o.is_eoi     = (op_q == cbtf_pkg::OP_EOI);
  assign sts_o.depth_zero = !has_top;
  assign sts_o.depth_le1  = (depth_q <= DepW'(1));
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the conditional block token filter. Directives and
// ordinary tokens go in on the token channel. Each accepted beat runs through
// a nesting-stack predictor, which queues the results the block must return.
// Returned beats are checked in order against that queue, under varying
// sender gaps, receiver stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;
  import cbtf_pkg::*;

  localparam int unsigned NEST_D        = NestDepthDef;
  localparam int unsigned HOLD_CYCLES   = 250;
  localparam int unsigned DRAIN_CYCLES  = 40;
  localparam int unsigned PHASE_ITEMS   = 75;
  localparam int unsigned NOISE_PCT     = 15;
  localparam int unsigned RUN_LIMIT_NS  = 5_000_000;
  localparam logic [LineW-1:0] LINE_MAX = '1;

  typedef struct {
    logic [OpW-1:0]   op;
    logic             cond;
    logic [LineW-1:0] line;
  } token_t;

  typedef struct {
    logic             pass;
    logic [ErrW-1:0]  err_code;
    logic [LineW-1:0] err_line;
    logic             last;
  } result_t;

  logic clk_i;
  logic rst_ni;

  cbtf_tok_if tok ();
  cbtf_res_if res ();

  conditional_block_token_filter_top #(
    .NEST_DEPTH(NEST_D)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tok_i  (tok),
    .res_o  (res)
  );

  token_t      token_q[$];
  result_t     pending_results[$];
  result_t     want_beat;
  entry_t      nest_lvl[NEST_D];
  int unsigned open_lvls;
  int unsigned n_pushed;
  int unsigned n_accepted;
  int unsigned n_mismatch;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          tok_taken;
  bit          hold_on;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni    = 1'b0;
    tok.valid = 1'b0;
    tok.op    = OP_TOKEN;
    tok.cond  = 1'b0;
    tok.line  = '0;
    res.ready = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // --------------------------------------------------------------------------
  // nesting-stack predictor
  // --------------------------------------------------------------------------
  function automatic void open_level(logic act, logic doelse, logic [LineW-1:0] ln);
    nest_lvl[open_lvls] = '{seen: 1'b0, doelse: doelse, active: act, line: ln};
    open_lvls++;
  endfunction

  function automatic void filter_token(token_t t);
    result_t     outs[$];
    bit          has_top;
    int unsigned top;
    has_top = (open_lvls != 0);
    top     = has_top ? open_lvls - 1 : 0;
    case (t.op)
      OP_IF: begin
        if (open_lvls >= NEST_D) begin
          outs.push_back('{1'b0, ERR_OVERFLOW, t.line, 1'b0});
        end else if (!has_top || nest_lvl[top].active) begin
          open_level(t.cond, !t.cond, t.line);
        end else begin
          open_level(1'b0, 1'b0, t.line);
        end
      end
      OP_ELSEIF: begin
        if (!has_top) begin
          // stray elseif is reported, then opens a level like an if
          outs.push_back('{1'b0, ERR_ELSEIF_NO_IF, t.line, 1'b0});
          open_level(t.cond, !t.cond, t.line);
        end else if (nest_lvl[top].seen) begin
          outs.push_back('{1'b0, ERR_ELSEIF_AFTER, t.line, 1'b0});
          nest_lvl[top].active = 1'b0;
        end else if (t.cond) begin
          nest_lvl[top].active = nest_lvl[top].doelse;
          nest_lvl[top].doelse = 1'b0;
        end else begin
          nest_lvl[top].active = 1'b0;
        end
      end
      OP_ELSE: begin
        if (!has_top) begin
          outs.push_back('{1'b0, ERR_ELSE_NO_IF, t.line, 1'b0});
        end else if (nest_lvl[top].seen) begin
          outs.push_back('{1'b0, ERR_ELSE_AFTER, t.line, 1'b0});
          nest_lvl[top].active = 1'b0;
        end else begin
          nest_lvl[top].seen   = 1'b1;
          nest_lvl[top].active = nest_lvl[top].doelse;
        end
      end
      OP_ENDIF: begin
        if (!has_top) outs.push_back('{1'b0, ERR_ENDIF_NO_IF, t.line, 1'b0});
        else open_lvls--;
      end
      OP_EOI: begin
        // innermost unclosed level first, then the end marker
        while (open_lvls != 0) begin
          outs.push_back('{1'b0, ERR_UNCLOSED, nest_lvl[open_lvls - 1].line, 1'b0});
          open_lvls--;
        end
        outs.push_back('{1'b1, ERR_NONE, '0, 1'b0});
      end
      default: begin
        if (!has_top || nest_lvl[top].active) outs.push_back('{1'b1, ERR_NONE, '0, 1'b0});
      end
    endcase
    if (outs.size() != 0) outs[outs.size() - 1].last = 1'b1;
    foreach (outs[i]) pending_results.push_back(outs[i]);
  endfunction

  // --------------------------------------------------------------------------
  // driver: token beats change on the falling edge
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      tok.valid <= 1'b0;
    end else if (!tok.valid || tok_taken) begin
      if (token_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        tok.valid <= 1'b1;
        tok.op    <= token_q[0].op;
        tok.cond  <= token_q[0].cond;
        tok.line  <= token_q[0].line;
      end else begin
        tok.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni || hold_on) res.ready <= 1'b0;
    else res.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // --------------------------------------------------------------------------
  // monitor: accepted token beats feed the predictor, result beats are checked
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    tok_taken = 1'b0;
    if (rst_ni && tok.valid && tok.ready) begin
      tok_taken = 1'b1;
      filter_token(token_q.pop_front());
      n_accepted++;
    end
    if (rst_ni && res.valid && res.ready) begin
      if (pending_results.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("%0t: unexpected result beat pass=%0b code=%0d line=%0d last=%0b",
                   $realtime, res.pass, res.err_code, res.err_line, res.last);
      end else begin
        want_beat = pending_results.pop_front();
        if (res.pass !== want_beat.pass || res.err_code !== want_beat.err_code ||
            res.err_line !== want_beat.err_line || res.last !== want_beat.last) begin
          n_mismatch++;
          if (n_mismatch <= 10) begin
            $write("%0t: result mismatch: expected pass=%0b code=%0d line=%0d last=%0b,",
                   $realtime, want_beat.pass, want_beat.err_code, want_beat.err_line,
                   want_beat.last);
            $display(" got pass=%0b code=%0d line=%0d last=%0b",
                     res.pass, res.err_code, res.err_line, res.last);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  task automatic add_token(logic [OpW-1:0] op, logic cond, logic [LineW-1:0] ln);
    token_q.push_back('{op, cond, ln});
    n_pushed++;
  endtask

  function automatic logic [LineW-1:0] rand_line();
    case ($urandom_range(7))
      0: return '0;
      1: return LINE_MAX;
      default: return LineW'($urandom);
    endcase
  endfunction

  // mostly well-nested directives with random content, plus some raw noise
  task automatic gen_program(int unsigned n_toks, int unsigned open_pct);
    int unsigned    lvl;
    bit             else_done[NEST_D + 1];
    int unsigned    r;
    logic [OpW-1:0] op;
    lvl = 0;
    for (int unsigned i = 0; i < n_toks; i++) begin
      if ($urandom_range(99) < NOISE_PCT) begin
        op = OpW'($urandom_range(7));
        add_token(op, 1'($urandom), rand_line());
        if (op == OP_IF && lvl < NEST_D) begin
          lvl++;
          else_done[lvl] = 1'b0;
        end else if (op == OP_ENDIF && lvl != 0) begin
          lvl--;
        end else if (op == OP_EOI) begin
          lvl = 0;
        end
      end else begin
        r = $urandom_range(99);
        if (r < open_pct) begin
          add_token(OP_IF, 1'($urandom), rand_line());
          // at full depth this one overflows and opens nothing
          if (lvl < NEST_D) begin
            lvl++;
            else_done[lvl] = 1'b0;
          end
        end else if (lvl != 0 && r < open_pct + 10 && !else_done[lvl]) begin
          add_token(OP_ELSEIF, 1'($urandom), rand_line());
        end else if (lvl != 0 && r < open_pct + 18 && !else_done[lvl]) begin
          add_token(OP_ELSE, 1'($urandom), rand_line());
          else_done[lvl] = 1'b1;
        end else if (lvl != 0 && r < open_pct + 35) begin
          add_token(OP_ENDIF, 1'($urandom), rand_line());
          lvl--;
        end else begin
          add_token(OP_TOKEN, 1'($urandom), rand_line());
        end
      end
    end
    if ($urandom_range(1) == 0) begin
      while (lvl != 0) begin
        add_token(OP_ENDIF, 1'($urandom), rand_line());
        lvl--;
      end
    end
    add_token(OP_EOI, 1'($urandom), rand_line());
  endtask

  task automatic gen_phase(int unsigned n_items);
    int unsigned stop_at;
    stop_at = n_pushed + n_items;
    while (n_pushed < stop_at) gen_program($urandom_range(6, 30), $urandom_range(20, 45));
  endtask

  task automatic wait_sent();
    while (token_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin : backpressure
    hold_on = 1'b0;
    wait (n_accepted >= 40);
    @(posedge clk_i);
    hold_on = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_on = 1'b0;
  end

  initial begin : stimulus
    n_pushed       = 0;
    n_accepted     = 0;
    n_mismatch     = 0;
    open_lvls      = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;

    // directed part
    add_token(OP_TOKEN, 1'b0, '0);
    add_token(3'd6, 1'b1, LINE_MAX);         // unused codes pass like tokens
    add_token(3'd7, 1'b0, 24'h5A5A5A);
    add_token(OP_ELSEIF, 1'b1, LINE_MAX);    // no open if: error, then opens
    add_token(OP_ELSEIF, 1'b0, 24'd20);
    add_token(OP_TOKEN, 1'b1, 24'd21);       // dropped
    add_token(OP_ELSE, 1'b0, 24'd22);
    add_token(OP_ELSE, 1'b0, 24'd23);        // else after else
    add_token(OP_ELSEIF, 1'b1, 24'd24);      // elseif after else
    add_token(OP_ENDIF, 1'b0, 24'd25);
    add_token(OP_ENDIF, 1'b1, LINE_MAX);     // endif with nothing open
    add_token(OP_ELSE, 1'b1, '0);            // else with nothing open
    add_token(OP_IF, 1'b0, 24'd5);
    add_token(OP_IF, 1'b1, 24'd6);           // nested inside a dead level
    add_token(OP_TOKEN, 1'b0, 24'd7);
    add_token(OP_ENDIF, 1'b0, 24'd8);
    add_token(OP_ELSEIF, 1'b1, 24'd9);       // takes the pending branch
    add_token(OP_TOKEN, 1'b0, 24'd10);
    add_token(OP_EOI, 1'b0, 24'd11);         // one unclosed level

    // full stack, one overflow, then end of input with every level open
    for (int unsigned i = 0; i <= NEST_D; i++) add_token(OP_IF, 1'($urandom), rand_line());
    add_token(OP_EOI, 1'($urandom), rand_line());

    gen_phase(PHASE_ITEMS);
    wait_sent();

    send_idle_pct = 66;
    gen_phase(PHASE_ITEMS);
    wait_sent();

    send_idle_pct  = 0;
    recv_stall_pct = 66;
    gen_phase(PHASE_ITEMS);
    wait_sent();

    send_idle_pct  = 20;
    recv_stall_pct = 20;
    gen_phase(PHASE_ITEMS);
    wait_sent();

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (n_mismatch == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== conditional_block_token_filter_top.f =====
+incdir+rtl
rtl/cbtf_pkg.sv
rtl/cbtf_tok_if.sv
rtl/cbtf_res_if.sv
rtl/cbtf_ctrl.sv
rtl/cbtf_datapath.sv
rtl/conditional_block_token_filter_top.sv
bench/testbench.sv
